>>> sv/client_id_bitmap_allocator_assert.svh
// Assertion macros shared by the allocator RTL.
`ifndef CLIENT_ID_BITMAP_ALLOCATOR_ASSERT_SVH
`define CLIENT_ID_BITMAP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CIDBA_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("cidba: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define CIDBA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("cidba: next-cycle check failed");

`endif

>>> sv/cidba_pkg.sv
package cidba_pkg;

    localparam int ID_BITS    = 8;
    localparam int OUT_OCTETS = 32;

    localparam logic [1:0] ACT_FIND      = 2'd0;
    localparam logic [1:0] ACT_MARK_USED = 2'd1;
    localparam logic [1:0] ACT_MARK_FREE = 2'd2;

    // Map memory access request between the sequencer and the map RAM.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } map_req_t;

    // Position of the lowest clear bit of an octet (caller checks one exists).
    function automatic logic [2:0] lowest_zero(input logic [7:0] octet);
        logic [2:0] pos;
        pos = 3'd0;
        for (int i = ID_BITS - 1; i >= 0; i--) begin
            if (!octet[i]) begin
                pos = 3'(i);
            end
        end
        return pos;
    endfunction

endpackage

>>> sv/client_id_bitmap_allocator.sv
// Client identifier allocator over an in-use map of MAP_OCTETS octets (256 bits by default).
// Input channel s_*: one request per transaction. s_action selects find the
// lowest free id, mark s_target_id used, or mark s_target_id free.
// s_fixed_client starts a find at id 1, otherwise at DYNAMIC_FIRST_OCTET*8.
// Result channel m_*: exactly one transaction per request, in order.
// m_free_id carries the id found (0 otherwise), m_none_free flags a failed find.
// A find reads octets, one map read per cycle, until a clear bit shows up
// (at most LIMIT octets, the lesser of MAP_OCTETS and 32).
// A mark reads the target octet, then modifies and writes it back; an ignored
// request presents its result at the accepting edge itself if the output is free.
// Requests are handled one at a time: the next request is taken once the
// result has moved into the output register.
// Reset (aresetn low, synchronous) clears the map at once through per-octet
// valid bits and empties the output register; no clearing pass is needed.
// When the receiver stalls, the result waits in the output register while the
// next request is processed; that request then holds its result internally
// and takes no further request until the output register frees up.
module client_id_bitmap_allocator
    import cidba_pkg::*;
#(
    parameter int MAP_OCTETS          = 32,
    parameter int DYNAMIC_FIRST_OCTET = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_action,
    input  logic       s_fixed_client,
    input  logic [7:0] s_target_id,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_free_id,
    output logic       m_none_free
);

    `include "client_id_bitmap_allocator_assert.svh"

    localparam int AW    = $clog2(MAP_OCTETS);
    // A find never looks past the octets an 8-bit id can name.
    localparam int LIMIT = (MAP_OCTETS < OUT_OCTETS) ? MAP_OCTETS : OUT_OCTETS;
    localparam bit DYN_OK = (DYNAMIC_FIRST_OCTET < LIMIT);
    localparam logic [AW-1:0] DYN_ADDR  = AW'(DYNAMIC_FIRST_OCTET);
    localparam logic [AW-1:0] LAST_ADDR = AW'(LIMIT - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_MARK = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]    state_reg,       state_next;
    logic [AW-1:0] op_addr_reg,     op_addr_next;
    logic [2:0]    bit_reg,         bit_next;
    logic          set_reg,         set_next;
    logic [7:0]    res_id_reg,      res_id_next;
    logic          res_none_reg,    res_none_next;
    logic          m_valid_reg,     m_valid_next;
    logic [7:0]    m_free_id_reg,   m_free_id_next;
    logic          m_none_free_reg, m_none_free_next;

    map_req_t      map_req;
    logic [AW-1:0] rd_addr;
    logic [7:0]    wr_data;
    logic [7:0]    rd_data;

    logic          fin;
    logic [7:0]    fin_id;
    logic          fin_none;
    logic          out_free;
    logic [7:0]    scan_octet;
    logic [7:0]    bit_mask;
    logic [15:0]   id_calc;
    logic          cid_in_map;

    cidba_map_ram #(
        .DEPTH (MAP_OCTETS),
        .AW    (AW)
    ) u_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (map_req),
        .rd_addr (rd_addr),
        .wr_addr (op_addr_reg),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_free_id   = m_free_id_reg;
    assign m_none_free = m_none_free_reg;
    assign out_free    = !m_valid_reg || m_ready;

    // Id 0 is reserved: treat its bit as always taken.
    assign scan_octet = rd_data | ((op_addr_reg == '0) ? 8'h01 : 8'h00);
    assign id_calc    = 16'(op_addr_reg) * 16'(ID_BITS) + 16'(lowest_zero(scan_octet));
    assign bit_mask   = 8'h01 << bit_reg;
    assign cid_in_map = (32'(s_target_id[7:3]) < MAP_OCTETS);

    always_comb begin
        state_next       = state_reg;
        op_addr_next     = op_addr_reg;
        bit_next         = bit_reg;
        set_next         = set_reg;
        res_id_next      = res_id_reg;
        res_none_next    = res_none_reg;
        m_valid_next     = m_valid_reg;
        m_free_id_next   = m_free_id_reg;
        m_none_free_next = m_none_free_reg;
        map_req          = '0;
        rd_addr          = op_addr_reg;
        wr_data          = set_reg ? (rd_data | bit_mask) : (rd_data & ~bit_mask);
        fin              = 1'b0;
        fin_id           = 8'h00;
        fin_none         = 1'b0;

        // Drop the held result once the receiver takes it.
        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_action) inside
                        ACT_FIND: begin
                            if (s_fixed_client || DYN_OK) begin
                                map_req.rd_en = 1'b1;
                                rd_addr       = s_fixed_client ? '0 : DYN_ADDR;
                                op_addr_next  = rd_addr;
                                state_next    = ST_SCAN;
                            end else begin
                                fin      = 1'b1;
                                fin_none = 1'b1;
                            end
                        end
                        ACT_MARK_USED, ACT_MARK_FREE: begin
                            if (cid_in_map) begin
                                map_req.rd_en = 1'b1;
                                rd_addr       = AW'(s_target_id[7:3]);
                                op_addr_next  = rd_addr;
                                bit_next      = s_target_id[2:0];
                                set_next      = (s_action == ACT_MARK_USED);
                                state_next    = ST_MARK;
                            end else begin
                                fin = 1'b1;
                            end
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // Data for op_addr_reg is in; fetch the next octet if this one is full and not the last.
                if (scan_octet != 8'hFF) begin
                    fin    = 1'b1;
                    fin_id = id_calc[7:0];
                end else if (op_addr_reg == LAST_ADDR) begin
                    fin      = 1'b1;
                    fin_none = 1'b1;
                end else begin
                    map_req.rd_en = 1'b1;
                    rd_addr       = op_addr_reg + AW'(1);
                    op_addr_next  = rd_addr;
                end
            end
            ST_MARK: begin
                map_req.wr_en = 1'b1;
                fin           = 1'b1;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_free_id_next   = res_id_reg;
                    m_none_free_next = res_none_reg;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Deliver a finished result, or hold it until the output register frees.
        if (fin) begin
            if (out_free) begin
                m_valid_next     = 1'b1;
                m_free_id_next   = fin_id;
                m_none_free_next = fin_none;
                state_next       = ST_IDLE;
            end else begin
                res_id_next   = fin_id;
                res_none_next = fin_none;
                state_next    = ST_DONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_addr_reg     <= op_addr_next;
        bit_reg         <= bit_next;
        set_reg         <= set_next;
        res_id_reg      <= res_id_next;
        res_none_reg    <= res_none_next;
        m_free_id_reg   <= m_free_id_next;
        m_none_free_reg <= m_none_free_next;
    end

    `CIDBA_ASSERT_NOW(a_scan_in_range, aclk, aresetn, (state_reg == ST_SCAN), (32'(op_addr_reg) < LIMIT))
    `CIDBA_ASSERT_NOW(a_no_rd_wr_clash, aclk, aresetn, map_req.wr_en, !map_req.rd_en)
    `CIDBA_ASSERT_NOW(a_none_means_zero, aclk, aresetn, (m_valid && m_none_free), (m_free_id == 8'h00))
    `CIDBA_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, (s_valid && s_ready && (state_next != ST_IDLE)), !s_ready)

endmodule

>>> sv/cidba_map_ram.sv
module cidba_map_ram
    import cidba_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  map_req_t      req,
    input  logic [AW-1:0] rd_addr,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    output logic [7:0]    rd_data
);

    logic [7:0]       mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [7:0]       rd_data_reg;

    // Entries never written since reset read as all clear.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (req.wr_en) begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= vld_reg[rd_addr] ? mem[rd_addr] : 8'h00;
        end
    end

    assign rd_data = rd_data_reg;

endmodule
